// File: rtl/hex8_pkg.sv
// hex8_pkg: shared types and constants for the hex8 shape and strain core.
// Corner sign table, Jacobian array type and the stage control struct.
// No dependencies.
package hex8_pkg;

  localparam int NODE_COUNT = 8;
  localparam int NODE_W     = 3;
  localparam int JAC_N      = 9;
  localparam int AXIS_N     = 3;

  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);

  // corner signs per node: bit0 xi, bit1 eta, bit2 zeta; set means plus
  localparam logic [NODE_COUNT-1:0][AXIS_N-1:0] CORNER_PLUS = {
    3'd6, 3'd7, 3'd5, 3'd4, 3'd2, 3'd3, 3'd1, 3'd0
  };

  typedef logic signed [31:0]    jac_word_t;
  // element 3*r + c holds row r, column c
  typedef jac_word_t [JAC_N-1:0] jac_arr_t;

  typedef struct packed {
    logic                valid;
    logic [NODE_W-1:0]   node;
    logic [AXIS_N-1:0]   plus;
    logic                last;
  } stage_ctl_t;

endpackage

// File: rtl/hex8_shape_and_strain_terms_core.sv
// hex8_shape_and_strain_terms_core: top level of the 8-node hexahedron evaluator.
// Instantiates hex8_issue, hex8_shape and hex8_strain; depends on hex8_pkg.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  coord_xi/eta/zeta, inv_jac_00..22
//   out      output     out_valid/out_stall  node_index, shape_value,
//                                            deriv_x/y/z, last_node
//
// One input transaction yields eight output transactions, one per cycle unless
// out_stall holds a waiting result; the node sequencer issues one node per
// advancing cycle, and a new item can be taken in the cycle its last node issues.
// The pipeline (holding register, factor, product, rounding, Jacobian product,
// output) moves as one and freezes while out_stall holds a waiting result.
// Synchronous reset clears the valid flag, node counter and stage control structs only.
module hex8_shape_and_strain_terms_core #(
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] coord_xi,
  input  logic signed [15:0] coord_eta,
  input  logic signed [15:0] coord_zeta,
  input  logic signed [31:0] inv_jac_00,
  input  logic signed [31:0] inv_jac_01,
  input  logic signed [31:0] inv_jac_02,
  input  logic signed [31:0] inv_jac_10,
  input  logic signed [31:0] inv_jac_11,
  input  logic signed [31:0] inv_jac_12,
  input  logic signed [31:0] inv_jac_20,
  input  logic signed [31:0] inv_jac_21,
  input  logic signed [31:0] inv_jac_22,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         node_index,
  output logic [14:0]        shape_value,
  output logic signed [31:0] deriv_x,
  output logic signed [31:0] deriv_y,
  output logic signed [31:0] deriv_z,
  output logic               last_node
);

  localparam int F = COORD_FRAC_BITS;

  logic                   advance;
  hex8_pkg::jac_arr_t     jac_in;
  hex8_pkg::stage_ctl_t   s1_ctl;
  logic [F+1:0]           s1_fx;
  logic [F+1:0]           s1_fy;
  logic [F+1:0]           s1_fz;
  hex8_pkg::jac_arr_t     s1_jac;
  hex8_pkg::stage_ctl_t   s3_ctl;
  logic [F+2:0]           s3_t;
  logic [F+1:0]           s3_fz;
  logic signed [F:0]      s3_dxi;
  logic signed [F:0]      s3_deta;
  logic signed [F:0]      s3_dzeta;
  hex8_pkg::jac_arr_t     s3_jac;
  hex8_pkg::stage_ctl_t   out_ctl;

  assign jac_in = {inv_jac_22, inv_jac_21, inv_jac_20,
                   inv_jac_12, inv_jac_11, inv_jac_10,
                   inv_jac_02, inv_jac_01, inv_jac_00};

  // whole pipeline moves unless a result waits at a stalled output
  assign advance = !out_ctl.valid || !out_stall;

  hex8_issue #(.COORD_FRAC_BITS(F)) u_issue (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .coord_xi   (coord_xi),
    .coord_eta  (coord_eta),
    .coord_zeta (coord_zeta),
    .jac_in     (jac_in),
    .s1_ctl     (s1_ctl),
    .s1_fx      (s1_fx),
    .s1_fy      (s1_fy),
    .s1_fz      (s1_fz),
    .s1_jac     (s1_jac)
  );

  hex8_shape #(.COORD_FRAC_BITS(F)) u_shape (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .s1_ctl   (s1_ctl),
    .s1_fx    (s1_fx),
    .s1_fy    (s1_fy),
    .s1_fz    (s1_fz),
    .s1_jac   (s1_jac),
    .s3_ctl   (s3_ctl),
    .s3_t     (s3_t),
    .s3_fz    (s3_fz),
    .s3_dxi   (s3_dxi),
    .s3_deta  (s3_deta),
    .s3_dzeta (s3_dzeta),
    .s3_jac   (s3_jac)
  );

  hex8_strain #(.COORD_FRAC_BITS(F)) u_strain (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .s3_ctl    (s3_ctl),
    .s3_t      (s3_t),
    .s3_fz     (s3_fz),
    .s3_dxi    (s3_dxi),
    .s3_deta   (s3_deta),
    .s3_dzeta  (s3_dzeta),
    .s3_jac    (s3_jac),
    .out_ctl   (out_ctl),
    .out_shape (shape_value),
    .out_dx    (deriv_x),
    .out_dy    (deriv_y),
    .out_dz    (deriv_z)
  );

  assign out_valid  = out_ctl.valid;
  assign node_index = out_ctl.node;
  assign last_node  = out_ctl.last;

endmodule

// File: rtl/hex8_issue.sv
// hex8_issue: input holding register, node sequencer and factor stage.
// Clamps the coordinates on capture, then issues one node per cycle while advance is high.
// Depends on hex8_pkg.
module hex8_issue #(
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              coord_xi,
  input  logic signed [15:0]              coord_eta,
  input  logic signed [15:0]              coord_zeta,
  input  hex8_pkg::jac_arr_t              jac_in,
  output hex8_pkg::stage_ctl_t            s1_ctl,
  output logic [COORD_FRAC_BITS+1:0]      s1_fx,
  output logic [COORD_FRAC_BITS+1:0]      s1_fy,
  output logic [COORD_FRAC_BITS+1:0]      s1_fz,
  output hex8_pkg::jac_arr_t              s1_jac
);

  localparam int FW = COORD_FRAC_BITS + 2;
  localparam int CW = (FW > 17) ? FW : 17;
  localparam logic signed [CW-1:0] ONE_C = CW'(1) << COORD_FRAC_BITS;
  localparam logic signed [FW:0]   ONE_F = (FW + 1)'(1) << COORD_FRAC_BITS;

  logic                              hold_valid;
  logic [hex8_pkg::NODE_W-1:0]       cnt;
  logic signed [FW-1:0]              hold_xi;
  logic signed [FW-1:0]              hold_eta;
  logic signed [FW-1:0]              hold_zeta;
  hex8_pkg::jac_arr_t                hold_jac;
  logic                              take;
  logic                              issue;
  logic                              issue_last;
  logic [hex8_pkg::AXIS_N-1:0]       plus;

  function automatic logic signed [FW-1:0] clamp(input logic signed [15:0] v);
    logic signed [CW-1:0] w;
    w = CW'(v);
    if (w > ONE_C) begin
      w = ONE_C;
    end else if (w < -ONE_C) begin
      w = -ONE_C;
    end
    return w[FW-1:0];
  endfunction

  // one +- coord, always in [0, 2*one]
  function automatic logic [FW-1:0] factor(input logic signed [FW-1:0] c,
                                           input logic p);
    logic signed [FW:0] s;
    s = p ? (ONE_F + (FW + 1)'(c)) : (ONE_F - (FW + 1)'(c));
    return s[FW-1:0];
  endfunction

  assign issue      = hold_valid && advance;
  assign issue_last = issue && (cnt == hex8_pkg::LAST_NODE);
  assign in_stall   = hold_valid && !issue_last;
  assign take       = in_valid && !in_stall;
  assign plus       = hex8_pkg::CORNER_PLUS[cnt];

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      cnt        <= '0;
      s1_ctl     <= '0;
    end else begin
      if (issue) begin
        cnt <= cnt + hex8_pkg::NODE_W'(1);
      end
      if (issue_last) begin
        hold_valid <= 1'b0;
      end
      if (take) begin
        hold_valid <= 1'b1;
        cnt        <= '0;
      end
      if (advance) begin
        s1_ctl.valid <= issue;
        s1_ctl.node  <= cnt;
        s1_ctl.plus  <= plus;
        s1_ctl.last  <= (cnt == hex8_pkg::LAST_NODE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_xi   <= clamp(coord_xi);
      hold_eta  <= clamp(coord_eta);
      hold_zeta <= clamp(coord_zeta);
      hold_jac  <= jac_in;
    end
    if (advance) begin
      s1_fx  <= factor(hold_xi, plus[0]);
      s1_fy  <= factor(hold_eta, plus[1]);
      s1_fz  <= factor(hold_zeta, plus[2]);
      s1_jac <= hold_jac;
    end
  end

  a_take_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (take && hold_valid) |-> issue_last)
    else $error("new transaction taken before the last node was issued");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !advance) |=> (hold_valid && $stable(cnt)))
    else $error("node sequencer moved during a stall");

  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    !hold_valid |-> (cnt == '0))
    else $error("node counter not at zero while idle");

endmodule

// File: rtl/hex8_shape.sv
// hex8_shape: factor products and rounding of t and the natural derivatives.
// Two register stages, both moving on the shared advance.
// Depends on hex8_pkg.
module hex8_shape #(
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  hex8_pkg::stage_ctl_t            s1_ctl,
  input  logic [COORD_FRAC_BITS+1:0]      s1_fx,
  input  logic [COORD_FRAC_BITS+1:0]      s1_fy,
  input  logic [COORD_FRAC_BITS+1:0]      s1_fz,
  input  hex8_pkg::jac_arr_t              s1_jac,
  output hex8_pkg::stage_ctl_t            s3_ctl,
  output logic [COORD_FRAC_BITS+2:0]      s3_t,
  output logic [COORD_FRAC_BITS+1:0]      s3_fz,
  output logic signed [COORD_FRAC_BITS:0] s3_dxi,
  output logic signed [COORD_FRAC_BITS:0] s3_deta,
  output logic signed [COORD_FRAC_BITS:0] s3_dzeta,
  output hex8_pkg::jac_arr_t              s3_jac
);

  localparam int F  = COORD_FRAC_BITS;
  localparam int FW = F + 2;
  localparam int TW = F + 3;
  localparam int PW = 2 * FW;
  localparam logic [PW:0] HALF_T = (PW + 1)'(1) << (F - 1);
  localparam logic [PW:0] HALF_D = (PW + 1)'(1) << (F + 2);

  hex8_pkg::stage_ctl_t s2_ctl;
  logic [PW-1:0]        p_xy;
  logic [PW-1:0]        p_yz;
  logic [PW-1:0]        p_xz;
  logic [FW-1:0]        s2_fz;
  hex8_pkg::jac_arr_t   s2_jac;
  logic [PW:0]          t_sum;

  // round half up by 2^(F+3), then apply the corner sign
  function automatic logic signed [F:0] dnat(input logic [PW-1:0] p,
                                             input logic pl);
    logic [PW:0]       s;
    logic signed [F:0] m;
    s = {1'b0, p} + HALF_D;
    m = $signed({1'b0, s[F+3 +: F]});
    return pl ? m : -m;
  endfunction

  assign t_sum = {1'b0, p_xy} + HALF_T;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
      s3_ctl <= '0;
    end else if (advance) begin
      s2_ctl <= s1_ctl;
      s3_ctl <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_xy     <= PW'(s1_fx) * PW'(s1_fy);
      p_yz     <= PW'(s1_fy) * PW'(s1_fz);
      p_xz     <= PW'(s1_fx) * PW'(s1_fz);
      s2_fz    <= s1_fz;
      s2_jac   <= s1_jac;
      s3_t     <= t_sum[F +: TW];
      s3_fz    <= s2_fz;
      s3_dxi   <= dnat(p_yz, s2_ctl.plus[0]);
      s3_deta  <= dnat(p_xz, s2_ctl.plus[1]);
      s3_dzeta <= dnat(p_xy, s2_ctl.plus[2]);
      s3_jac   <= s2_jac;
    end
  end

endmodule

// File: rtl/hex8_strain.sv
// hex8_strain: shape product and inverse Jacobian products, then rounding,
// saturation and the output register. Depends on hex8_pkg.
module hex8_strain #(
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  hex8_pkg::stage_ctl_t            s3_ctl,
  input  logic [COORD_FRAC_BITS+2:0]      s3_t,
  input  logic [COORD_FRAC_BITS+1:0]      s3_fz,
  input  logic signed [COORD_FRAC_BITS:0] s3_dxi,
  input  logic signed [COORD_FRAC_BITS:0] s3_deta,
  input  logic signed [COORD_FRAC_BITS:0] s3_dzeta,
  input  hex8_pkg::jac_arr_t              s3_jac,
  output hex8_pkg::stage_ctl_t            out_ctl,
  output logic [14:0]                     out_shape,
  output logic signed [31:0]              out_dx,
  output logic signed [31:0]              out_dy,
  output logic signed [31:0]              out_dz
);

  localparam int F   = COORD_FRAC_BITS;
  localparam int FW  = F + 2;
  localparam int TW  = F + 3;
  localparam int QW  = TW + FW;
  localparam int PRW = 33 + F;
  localparam int SUW = PRW + 2;
  localparam int SRW = SUW - F;
  localparam int SHW = F + 1;
  localparam int SXW = (SHW > 16) ? SHW : 16;
  localparam logic [QW:0]            HALF_S = (QW + 1)'(1) << (F + 2);
  localparam logic signed [SUW-1:0]  HALF_J = SUW'(1) << (F - 1);
  localparam logic signed [SRW-1:0]  S_MAX  = SRW'(32'sh7FFF_FFFF);
  localparam logic signed [SRW-1:0]  S_MIN  = SRW'(32'sh8000_0000);
  localparam logic [SXW-1:0]         SH_CAP = SXW'(32767);

  hex8_pkg::stage_ctl_t     s4_ctl;
  logic [QW-1:0]            q;
  logic signed [PRW-1:0]    prod [hex8_pkg::JAC_N];
  logic signed [F:0]        d [hex8_pkg::AXIS_N];
  logic [QW:0]              q_sum;
  logic [SXW-1:0]           sh_ext;

  // row sum, round half up by 2^F, saturate to 32 bits
  function automatic logic signed [31:0] deriv_sat(input logic signed [PRW-1:0] a,
                                                   input logic signed [PRW-1:0] b,
                                                   input logic signed [PRW-1:0] c);
    logic signed [SUW-1:0] s;
    logic signed [SRW-1:0] r;
    s = SUW'(a) + SUW'(b) + SUW'(c) + HALF_J;
    r = SRW'(s >>> F);
    if (r > S_MAX) begin
      r = S_MAX;
    end else if (r < S_MIN) begin
      r = S_MIN;
    end
    return r[31:0];
  endfunction

  always_comb begin
    d[0] = s3_dxi;
    d[1] = s3_deta;
    d[2] = s3_dzeta;
  end

  assign q_sum  = {1'b0, q} + HALF_S;
  assign sh_ext = SXW'(q_sum[F+3 +: SHW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_ctl  <= '0;
      out_ctl <= '0;
    end else if (advance) begin
      s4_ctl  <= s3_ctl;
      out_ctl <= s4_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      q <= QW'(s3_t) * QW'(s3_fz);
      for (int r = 0; r < hex8_pkg::AXIS_N; r++) begin
        for (int c = 0; c < hex8_pkg::AXIS_N; c++) begin
          prod[r*hex8_pkg::AXIS_N + c] <=
            PRW'($signed(s3_jac[r*hex8_pkg::AXIS_N + c])) * PRW'(d[c]);
        end
      end
      out_shape <= (sh_ext > SH_CAP) ? 15'h7FFF : sh_ext[14:0];
      out_dx    <= deriv_sat(prod[0], prod[1], prod[2]);
      out_dy    <= deriv_sat(prod[3], prod[4], prod[5]);
      out_dz    <= deriv_sat(prod[6], prod[7], prod[8]);
    end
  end

  a_s4_hold: assert property (@(posedge clk) disable iff (rst)
    (!advance && s4_ctl.valid) |=> (s4_ctl.valid && $stable(q)))
    else $error("product stage changed during a stall");

  a_last_is_node7: assert property (@(posedge clk) disable iff (rst)
    (out_ctl.valid && out_ctl.last) |-> (out_ctl.node == hex8_pkg::LAST_NODE))
    else $error("last flag on a node other than the final corner");

endmodule
